@@ design/sliding_window_min_2d_unit_defines.svh @@
// Assertion macros shared by the sliding window minimum checker.
`ifndef SLIDING_WINDOW_MIN_2D_UNIT_DEFINES_SVH
`define SLIDING_WINDOW_MIN_2D_UNIT_DEFINES_SVH

// Same-cycle implication, off during reset.
`define SWM2D_ASSERT_SAME(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("swm2d: same-cycle check failed");

// Next-cycle implication, off during reset.
`define SWM2D_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("swm2d: next-cycle check failed");

// State right after a reset edge.
`define SWM2D_ASSERT_RESET(label, post) \
    label: assert property (@(posedge i_clk) !i_rst_n |=> (post)) \
        else $error("swm2d: reset check failed");

`endif

@@ design/swm2d_pkg.sv @@
// Shared constants, types and the minimum tree function of the window minimum block.
`default_nettype none

package swm2d_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MAX_WIN_W  = 16;
    localparam int MAX_WIN_H  = 16;
    localparam int PIXEL_BITS = 16;

    // line store keeps the previous window rows per column
    localparam int LS_ROWS = (MAX_WIN_H > 1) ? MAX_WIN_H - 1 : 1;

    localparam int COL_BITS = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_BITS = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int IW_BITS  = $clog2(MAX_WIDTH + 1);
    localparam int IH_BITS  = $clog2(MAX_HEIGHT + 1);
    localparam int WW_BITS  = $clog2(MAX_WIN_W + 1);
    localparam int WH_BITS  = $clog2(MAX_WIN_H + 1);
    localparam int POS_A    = (IW_BITS > IH_BITS) ? IW_BITS : IH_BITS;
    localparam int POS_B    = (WW_BITS > WH_BITS) ? WW_BITS : WH_BITS;
    localparam int POS_BITS = (POS_A > POS_B) ? POS_A : POS_B;

    // register port field widths
    localparam int IMG_REG_BITS  = 11;
    localparam int WIN_REG_BITS  = 5;
    localparam int CFG_DATA_BITS = 11;
    localparam int CFG_IDX_BITS  = 2;
    localparam int OUT_POS_BITS  = 10;

    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_WIDTH = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_HEIGHT = 2'd3;

    localparam int RST_IMAGE_WIDTH   = (8 > MAX_WIDTH) ? MAX_WIDTH : 8;
    localparam int RST_IMAGE_HEIGHT  = (5 > MAX_HEIGHT) ? MAX_HEIGHT : 5;
    localparam int RST_WINDOW_WIDTH  = (3 > MAX_WIN_W) ? MAX_WIN_W : 3;
    localparam int RST_WINDOW_HEIGHT = (2 > MAX_WIN_H) ? MAX_WIN_H : 2;

    localparam int TREE_LEAVES   = (MAX_WIN_W > LS_ROWS + 1) ? MAX_WIN_W : LS_ROWS + 1;
    localparam int TREE_N        = 1 << $clog2(TREE_LEAVES);
    localparam int COL_DATA_BITS = LS_ROWS * PIXEL_BITS;

    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

    typedef logic [PIXEL_BITS-1:0] t_pix;
    typedef t_pix [TREE_N-1:0]     t_pix_tree;
    // entry 0 is the most recent row
    typedef t_pix [LS_ROWS-1:0]    t_col;

    typedef struct packed {
        logic [IW_BITS-1:0] img_w;
        logic [IH_BITS-1:0] img_h;
        logic [WW_BITS-1:0] win_w;
        logic [WH_BITS-1:0] win_h;
    } t_cfg;

    typedef struct packed {
        t_pix                    min_value;
        logic [OUT_POS_BITS-1:0] out_row;
        logic [OUT_POS_BITS-1:0] out_col;
        logic                    last_of_frame;
    } t_result;

    // balanced minimum over the leaves; unused leaves are set to all ones
    function automatic t_pix f_min_tree(input t_pix_tree v);
        t_pix_tree t;
        t = v;
        for (int s = TREE_N >> 1; s >= 1; s = s >> 1) begin
            for (int j = 0; j < s; j++) begin
                t[j] = (t[2*j+1] < t[2*j]) ? t[2*j+1] : t[2*j];
            end
        end
        return t[0];
    endfunction

endpackage

`default_nettype wire

@@ design/swm2d_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module swm2d_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ design/swm2d_cfg.sv @@
// Configuration registers with clamping of out-of-range values.
`default_nettype none

module swm2d_cfg
    import swm2d_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    output t_cfg                     o_cfg
);

    logic [IW_BITS-1:0] r_img_w, n_img_w;
    logic [IH_BITS-1:0] r_img_h, n_img_h;
    logic [WW_BITS-1:0] r_win_w, n_win_w;
    logic [WH_BITS-1:0] r_win_h, n_win_h;
    logic [IMG_REG_BITS-1:0] img_v;
    logic [WIN_REG_BITS-1:0] win_v;

    // zero reads as one, too large reads as the maximum
    always_comb begin
        img_v = i_cfg_data[IMG_REG_BITS-1:0];
        win_v = i_cfg_data[WIN_REG_BITS-1:0];

        if (img_v == '0)             n_img_w = IW_BITS'(1);
        else if (img_v > MAX_WIDTH)  n_img_w = IW_BITS'(MAX_WIDTH);
        else                         n_img_w = IW_BITS'(img_v);

        if (img_v == '0)             n_img_h = IH_BITS'(1);
        else if (img_v > MAX_HEIGHT) n_img_h = IH_BITS'(MAX_HEIGHT);
        else                         n_img_h = IH_BITS'(img_v);

        if (win_v == '0)             n_win_w = WW_BITS'(1);
        else if (win_v > MAX_WIN_W)  n_win_w = WW_BITS'(MAX_WIN_W);
        else                         n_win_w = WW_BITS'(win_v);

        if (win_v == '0)             n_win_h = WH_BITS'(1);
        else if (win_v > MAX_WIN_H)  n_win_h = WH_BITS'(MAX_WIN_H);
        else                         n_win_h = WH_BITS'(win_v);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= IW_BITS'(RST_IMAGE_WIDTH);
            r_img_h <= IH_BITS'(RST_IMAGE_HEIGHT);
            r_win_w <= WW_BITS'(RST_WINDOW_WIDTH);
            r_win_h <= WH_BITS'(RST_WINDOW_HEIGHT);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_IMAGE_WIDTH:   r_img_w <= n_img_w;
                REG_IMAGE_HEIGHT:  r_img_h <= n_img_h;
                REG_WINDOW_WIDTH:  r_win_w <= n_win_w;
                REG_WINDOW_HEIGHT: r_win_h <= n_win_h;
            endcase
        end
    end

    assign o_cfg = '{img_w: r_img_w, img_h: r_img_h, win_w: r_win_w, win_h: r_win_h};

endmodule

`default_nettype wire

@@ design/swm2d_hmin.sv @@
// Row pixel shift line and horizontal minimum over the active window width.
`default_nettype none

module swm2d_hmin
    import swm2d_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_shift,
    input  t_pix               i_pixel,
    input  logic [WW_BITS-1:0] i_win_w,
    output t_pix               o_hmin
);

    t_pix      r_window [MAX_WIN_W];
    t_pix_tree leaves;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_WIN_W; i++) begin
                r_window[i] <= '0;
            end
        end else if (i_shift) begin
            r_window[0] <= i_pixel;
            for (int i = 1; i < MAX_WIN_W; i++) begin
                r_window[i] <= r_window[i-1];
            end
        end
    end

    always_comb begin
        leaves = '1;
        for (int i = 0; i < MAX_WIN_W; i++) begin
            if (WW_BITS'(i) < i_win_w) begin
                leaves[i] = r_window[i];
            end
        end
        o_hmin = f_min_tree(leaves);
    end

endmodule

`default_nettype wire

@@ design/sliding_window_min_2d_unit.sv @@
// Top level: two-dimensional sliding window minimum over a raster pixel stream.
//
// Pixels enter on i_in_valid / o_in_stall, one transaction per pixel in raster
// order. For every full window_height x window_width window ending at a pixel,
// one result leaves on o_out_valid / i_out_stall with the window minimum, the
// window's top-left row and column, and a flag on the frame's last window.
// Throughput is one pixel per cycle while not stalled: each pixel reads
// the per-column line memory entry (all stored row minimums of that column) and
// writes it back once a full window width ends there, with forwarding from the
// two writes still in flight. A result moves through these registered steps:
// memory read at accept, horizontal minimum, vertical minimum into queue.
// A four-entry result queue decouples the receiver; input stalls only when
// queue contents plus pixels in flight reach four, so a stalled receiver
// blocks the input after a few more pixels and never loses a result.
// Reset or any register write restarts the frame at row 0, column 0; reset
// also loads the default geometry (8 x 5 image, 3 x 2 window). The line
// memory is not cleared: every stored row minimum that feeds a result is written earlier in the frame.
`default_nettype none

module sliding_window_min_2d_unit
    import swm2d_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [PIXEL_BITS-1:0]    i_pixel,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [PIXEL_BITS-1:0]    o_min_value,
    output logic [OUT_POS_BITS-1:0]  o_out_row,
    output logic [OUT_POS_BITS-1:0]  o_out_col,
    output logic                     o_last_of_frame
);

    typedef struct packed {
        logic [COL_BITS-1:0]     col;
        logic                    wr;
        logic                    prod;
        logic                    last;
        logic [OUT_POS_BITS-1:0] orow;
        logic [OUT_POS_BITS-1:0] ocol;
    } t_stage;

    t_cfg cfg;
    logic in_acc;

    logic [COL_BITS-1:0] r_col_cnt, n_col_cnt;
    logic [ROW_BITS-1:0] r_row_cnt, n_row_cnt;
    logic [POS_BITS-1:0] c_plus, r_plus, iw_ext, ih_ext, ww_ext, wh_ext;

    t_stage n_s1, r_s1, r_s2;
    logic   r_s1_valid, r_s2_valid;

    t_pix      hmin, r_s2_hmin, vmin;
    t_col      ram_rdata, fwd_col, r_s2_col, wr_col;
    t_pix_tree vtree;
    logic      mem_we;

    logic                r_lw_valid;
    logic [COL_BITS-1:0] r_lw_c;
    t_col                r_lw_data;

    t_result                  r_fifo [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] r_wptr, r_rptr;
    logic [FIFO_CNT_BITS-1:0] r_count;
    logic [FIFO_CNT_BITS:0]   in_flight;
    logic                     push, pop;
    t_result                  push_item, head;

    swm2d_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    assign in_flight = (FIFO_CNT_BITS + 1)'(r_count)
                     + (FIFO_CNT_BITS + 1)'(r_s1_valid)
                     + (FIFO_CNT_BITS + 1)'(r_s2_valid);
    assign o_in_stall = in_flight >= (FIFO_CNT_BITS + 1)'(FIFO_DEPTH);
    assign in_acc     = i_in_valid && !o_in_stall;

    // position bookkeeping at accept
    always_comb begin
        iw_ext = POS_BITS'(cfg.img_w);
        ih_ext = POS_BITS'(cfg.img_h);
        ww_ext = POS_BITS'(cfg.win_w);
        wh_ext = POS_BITS'(cfg.win_h);
        c_plus = POS_BITS'(r_col_cnt) + POS_BITS'(1);
        r_plus = POS_BITS'(r_row_cnt) + POS_BITS'(1);

        n_s1.col  = r_col_cnt;
        n_s1.wr   = c_plus >= ww_ext;
        n_s1.prod = (c_plus >= ww_ext) && (r_plus >= wh_ext);
        n_s1.last = (r_plus == ih_ext) && (c_plus == iw_ext);
        n_s1.orow = OUT_POS_BITS'(r_plus - wh_ext);
        n_s1.ocol = OUT_POS_BITS'(c_plus - ww_ext);

        if (c_plus >= iw_ext) begin
            n_col_cnt = '0;
            n_row_cnt = (r_plus >= ih_ext) ? '0 : ROW_BITS'(r_plus);
        end else begin
            n_col_cnt = COL_BITS'(c_plus);
            n_row_cnt = r_row_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt <= '0;
            r_row_cnt <= '0;
        end else if (i_cfg_we) begin
            r_col_cnt <= '0;
            r_row_cnt <= '0;
        end else if (in_acc) begin
            r_col_cnt <= n_col_cnt;
            r_row_cnt <= n_row_cnt;
        end
    end

    swm2d_hmin u_hmin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (in_acc),
        .i_pixel (i_pixel),
        .i_win_w (cfg.win_w),
        .o_hmin  (hmin)
    );

    assign mem_we = r_s2_valid && r_s2.wr;

    swm2d_ram #(
        .WIDTH (COL_DATA_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_s2.col),
        .i_wdata (wr_col),
        .i_re    (in_acc),
        .i_raddr (r_col_cnt),
        .o_rdata (ram_rdata)
    );

    // new column entry: this row's minimum in front, older rows move down
    always_comb begin
        wr_col[0] = r_s2_hmin;
        for (int i = 1; i < LS_ROWS; i++) begin
            wr_col[i] = r_s2_col[i-1];
        end
    end

    // narrow images revisit a column while its earlier writes are in flight; take the newest copy
    always_comb begin
        priority if (mem_we && (r_s2.col == r_s1.col)) begin
            fwd_col = wr_col;
        end else if (r_lw_valid && (r_lw_c == r_s1.col)) begin
            fwd_col = r_lw_data;
        end else begin
            fwd_col = ram_rdata;
        end
    end

    always_comb begin
        vtree    = '1;
        vtree[0] = r_s2_hmin;
        for (int k = 0; k < LS_ROWS; k++) begin
            if (WH_BITS'(k + 1) < cfg.win_h) begin
                vtree[k+1] = r_s2_col[k];
            end
        end
        vmin = f_min_tree(vtree);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_lw_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_acc;
            r_s2_valid <= r_s1_valid;
            r_lw_valid <= mem_we;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1      <= n_s1;
        r_s2      <= r_s1;
        r_s2_hmin <= hmin;
        r_s2_col  <= fwd_col;
        r_lw_c    <= r_s2.col;
        r_lw_data <= wr_col;
    end

    // result queue
    assign push      = r_s2_valid && r_s2.prod;
    assign pop       = o_out_valid && !i_out_stall;
    assign push_item = '{min_value:     vmin,
                         out_row:       r_s2.orow,
                         out_col:       r_s2.ocol,
                         last_of_frame: r_s2.last};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_count <= r_count + FIFO_CNT_BITS'(push) - FIFO_CNT_BITS'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wptr] <= push_item;
        end
    end

    assign head            = r_fifo[r_rptr];
    assign o_out_valid     = r_count != '0;
    assign o_min_value     = head.min_value;
    assign o_out_row       = head.out_row;
    assign o_out_col       = head.out_col;
    assign o_last_of_frame = head.last_of_frame;

endmodule

`default_nettype wire

@@ design/swm2d_checker.sv @@
// Port-level checker for the sliding window minimum block, bound to the top level.
`default_nettype none
`include "sliding_window_min_2d_unit_defines.svh"

module swm2d_checker
    import swm2d_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    o_in_stall,
    input logic                    o_out_valid,
    input logic                    i_out_stall,
    input logic [PIXEL_BITS-1:0]   o_min_value,
    input logic [OUT_POS_BITS-1:0] o_out_row,
    input logic [OUT_POS_BITS-1:0] o_out_col,
    input logic                    o_last_of_frame
);

    // a stalled result holds
    `SWM2D_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_min_value) && $stable(o_out_row) && $stable(o_out_col) && $stable(o_last_of_frame))

    // a result leaves only when taken
    `SWM2D_ASSERT_SAME(a_out_drop_taken, $fell(o_out_valid) && $past(i_rst_n), $past(!i_out_stall))

    // input backs up only behind queued results
    `SWM2D_ASSERT_SAME(a_stall_backlog, o_in_stall, o_out_valid)

    `SWM2D_ASSERT_RESET(a_reset_empty, !o_out_valid)

endmodule

bind sliding_window_min_2d_unit swm2d_checker u_swm2d_checker (.*);

`default_nettype wire
